### rtl/core/assert_macros.svh
// assertion macros, used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tksu_pkg.sv
// types, codes and reset values for the timed key sequence unlock block
// no dependencies
package tksu_pkg;

	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned SENT_W    = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_THIRD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN2_LO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN2_HI    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIN3_LO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIN3_HI    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NTF_DELAY  = 3'd7;

	// reset values
	localparam logic [CFG_W-1:0] RST_KEY_FIRST  = 16'd1122;
	localparam logic [CFG_W-1:0] RST_KEY_SECOND = 16'd2233;
	localparam logic [CFG_W-1:0] RST_KEY_THIRD  = 16'd3344;
	localparam logic [CFG_W-1:0] RST_WIN_LO     = 16'd500;
	localparam logic [CFG_W-1:0] RST_WIN_HI     = 16'd5000;
	localparam logic [CFG_W-1:0] RST_NTF_DELAY  = 16'd500;

	// phases
	localparam logic [1:0] PH_READY     = 2'd0;
	localparam logic [1:0] PH_ONE       = 2'd1;
	localparam logic [1:0] PH_TWO       = 2'd2;
	localparam logic [1:0] PH_RESETTING = 2'd3;

	// item kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [SENT_W-1:0] NOTIFY_LIMIT = 3'd4;
	localparam logic [1:0]        LAST_NOTIFY  = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] key_first;
		logic [CFG_W-1:0] key_second;
		logic [CFG_W-1:0] key_third;
		logic [CFG_W-1:0] win2_lo;
		logic [CFG_W-1:0] win2_hi;
		logic [CFG_W-1:0] win3_lo;
		logic [CFG_W-1:0] win3_hi;
		logic [CFG_W-1:0] ntf_delay;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [CFG_W-1:0]  command_code;
		logic [TIME_W-1:0] now_ms;
		logic              disarmed;
	} in_item_t;

	typedef struct packed {
		logic [1:0] unlock_state;
		logic       bootloader_request;
		logic       reset_notify;
		logic [1:0] notify_count;
		logic       system_reset;
	} out_item_t;

endpackage

### rtl/core/tksu_if.sv
// channel interfaces for input events and result items
// depends on tksu_pkg
interface tksu_in_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [tksu_pkg::CFG_W-1:0]    command_code;
	logic [tksu_pkg::TIME_W-1:0]   now_ms;
	logic                          disarmed;

	modport source (output valid, cmd, command_code, now_ms, disarmed, input ready);
	modport sink (input valid, cmd, command_code, now_ms, disarmed, output ready);
endinterface

interface tksu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] unlock_state;
	logic       bootloader_request;
	logic       reset_notify;
	logic [1:0] notify_count;
	logic       system_reset;

	modport source (output valid, unlock_state, bootloader_request, reset_notify,
		notify_count, system_reset, input ready);
	modport sink (input valid, unlock_state, bootloader_request, reset_notify,
		notify_count, system_reset, output ready);
endinterface

### rtl/core/tksu_cfg_regs.sv
// configuration register file, written through a plain write port
// depends on tksu_pkg
module tksu_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [tksu_pkg::CFG_IDX_W-1:0] index,
	input  logic [tksu_pkg::CFG_W-1:0]     data,
	output tksu_pkg::cfg_t                  cfg
);

	tksu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_first  <= tksu_pkg::RST_KEY_FIRST;
			cfg_q.key_second <= tksu_pkg::RST_KEY_SECOND;
			cfg_q.key_third  <= tksu_pkg::RST_KEY_THIRD;
			cfg_q.win2_lo    <= tksu_pkg::RST_WIN_LO;
			cfg_q.win2_hi    <= tksu_pkg::RST_WIN_HI;
			cfg_q.win3_lo    <= tksu_pkg::RST_WIN_LO;
			cfg_q.win3_hi    <= tksu_pkg::RST_WIN_HI;
			cfg_q.ntf_delay  <= tksu_pkg::RST_NTF_DELAY;
		end else if (wr_en) begin
			case (index)
				tksu_pkg::REG_KEY_FIRST:  cfg_q.key_first  <= data;
				tksu_pkg::REG_KEY_SECOND: cfg_q.key_second <= data;
				tksu_pkg::REG_KEY_THIRD:  cfg_q.key_third  <= data;
				tksu_pkg::REG_WIN2_LO:    cfg_q.win2_lo    <= data;
				tksu_pkg::REG_WIN2_HI:    cfg_q.win2_hi    <= data;
				tksu_pkg::REG_WIN3_LO:    cfg_q.win3_lo    <= data;
				tksu_pkg::REG_WIN3_HI:    cfg_q.win3_hi    <= data;
				tksu_pkg::REG_NTF_DELAY:  cfg_q.ntf_delay  <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/tksu_engine.sv
// unlock sequence state and the per-event step logic
// depends on tksu_pkg
module tksu_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  tksu_pkg::in_item_t   item,
	input  tksu_pkg::cfg_t       cfg,
	output tksu_pkg::out_item_t  result
);

	logic [1:0]                     phase_q, phase_d;
	logic [tksu_pkg::TIME_W-1:0]    last_cmd_q, last_cmd_d;
	logic [tksu_pkg::TIME_W-1:0]    last_ntf_q, last_ntf_d;
	logic [tksu_pkg::SENT_W-1:0]    sent_q, sent_d;
	logic [tksu_pkg::TIME_W-1:0]    gap;
	logic [tksu_pkg::TIME_W-1:0]    since_ntf;
	logic                           in_win2, in_win3;
	logic                           boot_req, notify, sys_reset;

	// gaps wrap modulo 2^32
	assign gap       = item.now_ms - last_cmd_q;
	assign since_ntf = item.now_ms - last_ntf_q;
	assign in_win2   = (gap > {16'd0, cfg.win2_lo}) && (gap < {16'd0, cfg.win2_hi});
	assign in_win3   = (gap > {16'd0, cfg.win3_lo}) && (gap < {16'd0, cfg.win3_hi});

	always_comb begin
		phase_d    = phase_q;
		last_cmd_d = last_cmd_q;
		last_ntf_d = last_ntf_q;
		sent_d     = sent_q;
		boot_req   = 1'b0;
		notify     = 1'b0;
		sys_reset  = 1'b0;
		if (item.cmd == tksu_pkg::CMD_WRITE) begin
			if (phase_q != tksu_pkg::PH_RESETTING) begin
				last_cmd_d = item.now_ms;
				case (phase_q)
					tksu_pkg::PH_READY: begin
						if (item.command_code == cfg.key_first)
							phase_d = tksu_pkg::PH_ONE;
					end
					tksu_pkg::PH_ONE: begin
						if (item.command_code == cfg.key_second && in_win2)
							phase_d = tksu_pkg::PH_TWO;
						else
							phase_d = tksu_pkg::PH_READY;
					end
					default: begin
						if (item.command_code == cfg.key_third && in_win3 && item.disarmed) begin
							boot_req   = 1'b1;
							sent_d     = '0;
							last_ntf_d = item.now_ms;
							phase_d    = tksu_pkg::PH_RESETTING;
						end else begin
							phase_d = tksu_pkg::PH_READY;
						end
					end
				endcase
			end
		end else if (phase_q == tksu_pkg::PH_RESETTING && sent_q < tksu_pkg::NOTIFY_LIMIT) begin
			if (since_ntf > {16'd0, cfg.ntf_delay}) begin
				last_ntf_d = item.now_ms;
				notify     = 1'b1;
				sent_d     = sent_q + 3'd1;
				sys_reset  = (sent_q[1:0] == tksu_pkg::LAST_NOTIFY);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= tksu_pkg::PH_READY;
			last_cmd_q <= '0;
			last_ntf_q <= '0;
			sent_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			last_cmd_q <= last_cmd_d;
			last_ntf_q <= last_ntf_d;
			sent_q     <= sent_d;
		end
	end

	assign result.unlock_state       = phase_d;
	assign result.bootloader_request = boot_req;
	assign result.reset_notify       = notify;
	assign result.notify_count       = notify ? sent_q[1:0] : 2'd0;
	assign result.system_reset       = sys_reset;

endmodule

### rtl/core/timed_key_sequence_unlock.sv
// top level of the timed key sequence unlock block
// depends on tksu_pkg, tksu_if, tksu_cfg_regs, tksu_engine and assert_macros.svh
//
// usage
// - events: valid/ready channel of command writes (cmd 0) and ticks (cmd 1),
//   each stamped with a wrapping millisecond time
// - results: valid/ready channel, exactly one result per event, in order
// - cfg_wr_en/cfg_index/cfg_data write the eight 16-bit registers; write only
//   while no event is in flight
// - an event transferred on events is held in the input register, stepped
//   through the sequence logic into the result register once that is free
//   or being read, and is offered on results from then on
// - one event per cycle sustained while results is ready; the state updates
//   each step, so back-to-back events see each other's effect without bubbles
// - when results stalls, the result register holds and the input register
//   fills; events then wait until a result transfer frees a stage
// - reset clears both stages, returns the sequence to ready with zeroed time
//   stamps and notify count, and restores the register defaults
`include "assert_macros.svh"

module timed_key_sequence_unlock (
	input  logic                            clk,
	input  logic                            arst_n,
	tksu_in_if.sink                         events,
	tksu_out_if.source                      results,
	input  logic                            cfg_wr_en,
	input  logic [tksu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tksu_pkg::CFG_W-1:0]     cfg_data
);

	tksu_pkg::cfg_t      cfg;
	tksu_pkg::in_item_t  item_in, item_s1;
	tksu_pkg::out_item_t res_comb, res_s2;
	logic                vld_s1, vld_s2;
	logic                adv, take;

	assign item_in.cmd          = events.cmd;
	assign item_in.command_code = events.command_code;
	assign item_in.now_ms       = events.now_ms;
	assign item_in.disarmed     = events.disarmed;

	assign adv           = vld_s1 && (!vld_s2 || results.ready);
	assign events.ready  = !vld_s1 || adv;
	assign take          = events.valid && events.ready;

	tksu_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tksu_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take)
				vld_s1 <= 1'b1;
			else if (adv)
				vld_s1 <= 1'b0;
			if (adv)
				vld_s2 <= 1'b1;
			else if (results.ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item_in;
		if (adv)
			res_s2 <= res_comb;
	end

	assign results.valid              = vld_s2;
	assign results.unlock_state       = res_s2.unlock_state;
	assign results.bootloader_request = res_s2.bootloader_request;
	assign results.reset_notify       = res_s2.reset_notify;
	assign results.notify_count       = res_s2.notify_count;
	assign results.system_reset       = res_s2.system_reset;

	`ASSERT_SAME(a_boot_enters_resetting, clk, arst_n,
		vld_s2 && res_s2.bootloader_request,
		res_s2.unlock_state == tksu_pkg::PH_RESETTING, "bootloader request outside resetting")
	`ASSERT_SAME(a_sysreset_on_last_notify, clk, arst_n,
		vld_s2 && res_s2.system_reset,
		res_s2.reset_notify && res_s2.notify_count == tksu_pkg::LAST_NOTIFY,
		"system reset without the fourth notify")
	`ASSERT_SAME(a_notify_only_resetting, clk, arst_n,
		vld_s2 && res_s2.reset_notify,
		res_s2.unlock_state == tksu_pkg::PH_RESETTING && !res_s2.bootloader_request,
		"notify outside resetting")
	`ASSERT_NEXT(a_advance_fills_result, clk, arst_n, adv, vld_s2,
		"stepped event did not reach the result register")

endmodule
